### rtl/tt_pkg.sv
package tt_pkg;

   // Table geometry: the low signature bits select one entry.
   localparam int INDEX_BITS = 12;
   localparam int TABLE_DEPTH = 1 << INDEX_BITS;

   // Field widths.
   localparam int SIG_W = 64;
   localparam int VAL_W = 16;
   localparam int TAG_W = 8;
   localparam int LIM_W = 15;
   localparam int CMD_W = 2;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 16;
   localparam int REQ_DATA_W = 144;
   localparam int RSP_DATA_W = 40;

   // Request commands.
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
   localparam logic [CMD_W-1:0] CMD_EXACT  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_BOUND  = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_BOUND_LIMIT   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIN_THRESHOLD = 4'd1;

   localparam logic [LIM_W-1:0] LIMIT_RESET = 15'h7FFF;

   // One table entry, 120 bits.
   typedef struct packed {
      logic [SIG_W-1:0]        sig;
      logic signed [VAL_W-1:0] lo;
      logic signed [VAL_W-1:0] hi;
      logic [TAG_W-1:0]        depth;
      logic [TAG_W-1:0]        move;
      logic [TAG_W-1:0]        base;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Controller commands to the datapath.
   typedef struct packed {
      logic accept;
      logic exec;
      logic clear;
   } ctrl_cmd_type;

   // Datapath status to the controller.
   typedef struct packed {
      logic is_lookup;
      logic out_room;
      logic clear_last;
   } ctrl_stat_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_EXEC  = 3'b100
   } state_type;

endpackage

### rtl/tt_ram.sv
module tt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/tt_ctrl.sv
module tt_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  tt_pkg::ctrl_stat_type stat,
   output tt_pkg::ctrl_cmd_type  cmd
);

   import tt_pkg::*;

   state_type state_ff;
   state_type state_in;

   // Sequencing: clear sweep after reset, then accept and execute one request at a time.
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            // A lookup waits here until the response register has room.
            if (!stat.is_lookup || stat.out_room) begin
               cmd.exec = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/tt_dpath.sv
module tt_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [tt_pkg::CMD_W-1:0]          req_tuser,
   input  logic [tt_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [1:0]                        rsp_tuser,
   output logic [tt_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                              csr_valid,
   input  logic [tt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tt_pkg::CSR_DAT_W-1:0]      csr_data,
   input  tt_pkg::ctrl_cmd_type              cmd,
   output tt_pkg::ctrl_stat_type             stat
);

   import tt_pkg::*;

   // Configuration registers.
   logic [LIM_W-1:0] bound_limit_ff;
   logic [LIM_W-1:0] win_threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bound_limit_ff   <= LIMIT_RESET;
         win_threshold_ff <= LIMIT_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_BOUND_LIMIT) begin
            bound_limit_ff <= csr_data[LIM_W-1:0];
         end else if (csr_index == CSR_WIN_THRESHOLD) begin
            win_threshold_ff <= csr_data[LIM_W-1:0];
         end
      end
   end

   // Clear sweep counter.
   logic [INDEX_BITS-1:0] clear_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
      end else if (cmd.clear) begin
         clear_cnt_ff <= clear_cnt_ff + 1'b1;
      end
   end

   // Request capture.
   logic [CMD_W-1:0]        cmd_ff;
   logic [SIG_W-1:0]        sig_ff;
   logic [TAG_W-1:0]        depth_ff;
   logic [TAG_W-1:0]        base_ff;
   logic signed [VAL_W-1:0] value_ff;
   logic signed [VAL_W-1:0] alpha_ff;
   logic signed [VAL_W-1:0] beta_ff;
   logic [TAG_W-1:0]        move_ff;
   logic                    has_move_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cmd_ff      <= req_tuser;
         sig_ff      <= req_tdata[63:0];
         depth_ff    <= req_tdata[71:64];
         base_ff     <= req_tdata[79:72];
         value_ff    <= req_tdata[95:80];
         alpha_ff    <= req_tdata[111:96];
         beta_ff     <= req_tdata[127:112];
         move_ff     <= req_tdata[135:128];
         has_move_ff <= req_tdata[136];
      end
   end

   // Entry memory.
   entry_type             entry;
   logic [ENTRY_W-1:0]    rd_word;
   logic                  wr_en;
   logic [INDEX_BITS-1:0] wr_addr;
   entry_type             wr_entry;
   entry_type             new_entry;
   logic                  store_go;

   tt_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (cmd.accept),
      .rd_addr (req_tdata[INDEX_BITS-1:0]),
      .rd_data (rd_word)
   );

   assign entry = rd_word;

   // Lookup evaluation.
   logic        match;
   logic [16:0] mag;
   logic        hit;

   always_comb begin
      match = (entry.sig == sig_ff);
      mag   = entry.lo[VAL_W-1] ? (17'd0 - {1'b1, entry.lo}) : {1'b0, entry.lo};
      hit   = match && ((entry.depth == depth_ff) ||
              ((entry.lo == entry.hi) && (mag >= {2'b00, win_threshold_ff})));
   end

   // Store evaluation: replacement test, fresh-bound reset and window narrowing.
   logic replace;
   logic fresh;

   always_comb begin
      replace   = (entry.base != base_ff) || (entry.depth <= depth_ff);
      fresh     = (entry.sig != sig_ff) || (entry.depth != depth_ff);
      new_entry = entry;
      store_go  = 1'b0;
      case (cmd_ff)
         CMD_EXACT: begin
            store_go        = replace;
            new_entry.lo    = value_ff;
            new_entry.hi    = value_ff;
            new_entry.depth = depth_ff;
            new_entry.move  = has_move_ff ? move_ff : 8'hFF;
            new_entry.base  = base_ff;
            new_entry.sig   = sig_ff;
         end
         CMD_BOUND: begin
            store_go = replace;
            if (fresh) begin
               new_entry.depth = depth_ff;
               new_entry.lo    = 16'sd0 - $signed({1'b0, bound_limit_ff});
               new_entry.hi    = $signed({1'b0, bound_limit_ff});
               new_entry.sig   = sig_ff;
            end
            new_entry.base = base_ff;
            if (has_move_ff) begin
               new_entry.move = move_ff;
            end
            if (value_ff <= alpha_ff) begin
               new_entry.hi = value_ff;
            end else if (value_ff >= beta_ff) begin
               new_entry.lo = value_ff;
            end else begin
               new_entry.lo = value_ff;
               new_entry.hi = value_ff;
            end
         end
         default: begin
            store_go = 1'b0;
         end
      endcase
   end

   // Write port: zeros during the sweep, updated entry on a store.
   always_comb begin
      wr_en    = cmd.clear || (cmd.exec && store_go);
      wr_addr  = cmd.clear ? clear_cnt_ff : sig_ff[INDEX_BITS-1:0];
      wr_entry = cmd.clear ? '0 : new_entry;
   end

   // Response register.
   logic                    rsp_valid_ff;
   logic                    hit_ff;
   logic                    known_ff;
   logic signed [VAL_W-1:0] lower_ff;
   logic signed [VAL_W-1:0] upper_ff;
   logic [TAG_W-1:0]        best_ff;
   logic                    load_rsp;

   assign load_rsp = cmd.exec && (cmd_ff == CMD_LOOKUP);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         hit_ff   <= hit;
         known_ff <= match;
         lower_ff <= hit ? entry.lo : '0;
         upper_ff <= hit ? entry.hi : '0;
         best_ff  <= match ? entry.move : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {known_ff, hit_ff};
   assign rsp_tdata  = {best_ff, upper_ff, lower_ff};

   // Status to the controller.
   always_comb begin
      stat.is_lookup  = (cmd_ff == CMD_LOOKUP);
      stat.out_room   = !rsp_valid_ff || rsp_tready;
      stat.clear_last = &clear_cnt_ff;
   end

endmodule

### rtl/transposition_table.sv
// Direct-mapped transposition table of 4096 entries, indexed by the low 12 bits of the
// signature. After reset the block runs a clearing pass over all entries, one entry per
// cycle, and accepts no request until it is done; register writes are taken at any time.
// Requests are taken one at a time: the accept cycle issues the entry read, and the
// execute state evaluates it and, for a store, writes the entry back through the single
// write port of the table memory. A lookup additionally waits while an earlier response
// is still held in the response register. Stores give no response; command 3 is dropped.
module transposition_table (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // req_tuser: command [1:0]
   input  logic [tt_pkg::CMD_W-1:0]          req_tuser,
   // req_tdata: signature [63:0], remaining_depth [71:64], search_base [79:72],
   // value [95:80], window_low [111:96], window_high [127:112], move_code [135:128],
   // move_present [136], zero [143:137]
   input  logic [tt_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // rsp_tuser: hit [0], move_known [1]
   output logic [1:0]                        rsp_tuser,
   // rsp_tdata: lower_bound [15:0], upper_bound [31:16], stored_move [39:32]
   output logic [tt_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tt_pkg::CSR_DAT_W-1:0]      csr_data
);

   import tt_pkg::*;

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   assign csr_ready = 1'b1;

   tt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tt_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule
